>>> sv/dlc_pkg.sv
`timescale 1ns / 1ps

package dlc_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int BYTE_BITS   = 8;
    localparam int LEN_BITS    = 16;
    localparam int ADDR_BITS   = 2 * SYMBOL_BITS;
    localparam int EPOCH_BITS  = 8;
    localparam int CMP_BITS    = (COUNT_BITS + 2 > LEN_BITS) ? COUNT_BITS + 2 : LEN_BITS;
    localparam int PAIR_LEN    = 2;

    typedef logic [BYTE_BITS-1:0]   byte_t;
    typedef logic [SYMBOL_BITS-1:0] psym_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [LEN_BITS-1:0]    len_t;
    typedef logic [EPOCH_BITS-1:0]  epoch_t;
    typedef logic [CMP_BITS-1:0]    cmp_t;

    localparam count_t COUNT_MAX   = '1;
    localparam len_t   LEN_MAX     = '1;
    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;

    typedef struct packed {
        epoch_t tag;
        count_t count;
    } entry_t;

    // read issued when a symbol that closes a pair is transferred
    typedef struct packed {
        logic  rd;
        addr_t addr;
    } dlc_req_t;

    // update of the entry read earlier; it waits in the update stage while stalled
    typedef struct packed {
        logic  wr;
        logic  seq_end;
        addr_t addr;
    } dlc_upd_t;

endpackage

>>> sv/dlc_seq_if.sv
`timescale 1ns / 1ps

interface dlc_seq_if;
    import dlc_pkg::*;

    logic  valid;
    logic  ready;
    byte_t symbol;
    logic  last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> sv/dlc_result_if.sv
`timescale 1ns / 1ps

interface dlc_result_if;
    import dlc_pkg::*;

    logic valid;
    logic ready;
    logic low_complexity;
    len_t seq_length;

    modport source (output valid, output low_complexity, output seq_length, input ready);
    modport sink   (input valid, input low_complexity, input seq_length, output ready);
endinterface

>>> sv/dlc_pair_table.sv
`timescale 1ns / 1ps

module dlc_pair_table (
    input  logic              clk,
    input  logic              rst_n,
    input  dlc_pkg::dlc_req_t req,
    input  dlc_pkg::dlc_upd_t upd,
    output dlc_pkg::count_t   max_next,
    output logic              busy
);
    import dlc_pkg::*;

    entry_t mem [2**ADDR_BITS];
    entry_t rdata_reg;

    logic   sweep_reg, sweep_next;
    addr_t  sweep_idx_reg, sweep_idx_next;
    epoch_t epoch_reg, epoch_next;
    count_t max_reg, max_next_reg_val;
    logic   fwd_valid_reg, fwd_valid_next;
    addr_t  fwd_addr_reg;
    count_t fwd_count_reg;
    count_t base;
    count_t cnt_new;

    assign busy = sweep_reg;

    // entries tagged with an older epoch belong to an earlier sequence
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == upd.addr)
            base = fwd_count_reg;
        else if (rdata_reg.tag == epoch_reg)
            base = rdata_reg.count;
        else
            base = '0;
        cnt_new = (base == COUNT_MAX) ? base : base + count_t'(1);
    end

    always_comb
    begin
        max_next_reg_val = max_reg;
        if (upd.wr && cnt_new > max_reg)
            max_next_reg_val = cnt_new;
    end

    assign max_next = max_next_reg_val;

    always_comb
    begin
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        epoch_next     = epoch_reg;
        fwd_valid_next = fwd_valid_reg;
        if (sweep_reg)
        begin
            sweep_idx_next = sweep_idx_reg + addr_t'(1);
            if (&sweep_idx_reg)
                sweep_next = 1'b0;
        end
        if (upd.wr)
            fwd_valid_next = 1'b1;
        if (upd.seq_end)
        begin
            fwd_valid_next = 1'b0;
            if (epoch_reg == EPOCH_LAST)
            begin
                // tags run out: wipe the table before reusing them
                epoch_next     = EPOCH_FIRST;
                sweep_next     = 1'b1;
                sweep_idx_next = '0;
            end
            else
                epoch_next = epoch_reg + epoch_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            epoch_reg     <= EPOCH_FIRST;
            max_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            epoch_reg     <= epoch_next;
            max_reg       <= upd.seq_end ? '0 : max_next_reg_val;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.wr)
        begin
            fwd_addr_reg  <= upd.addr;
            fwd_count_reg <= cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
            mem[sweep_idx_reg] <= '0;
        else if (upd.wr)
            mem[upd.addr] <= '{tag: epoch_reg, count: cnt_new};
        if (req.rd)
            rdata_reg <= mem[req.addr];
    end

    a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !req.rd && !upd.wr)
        else $error("table access during clearing pass");

    a_max_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        upd.seq_end |=> max_reg == '0)
        else $error("maximum not cleared at end of sequence");

    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch tag equals the cleared tag");

endmodule

>>> sv/dimer_low_complexity_check.sv
`timescale 1ns / 1ps

// Channel  Modport  Payload                       Transfer
// seq      sink     symbol[7:0], last             one symbol per transfer
// result   source   low_complexity, seq_length    one per sequence, on last
//
// One symbol per cycle within a sequence: the pair table is read on the
// transfer cycle and written back the next, forwarding the last write.
// The last symbol holds seq.ready low while it sits in the
// update stage, and longer while the result register is still full.
// After reset, and after every 255 sequences, a clearing pass writes all
// 65536 table entries, one per cycle, with seq.ready low throughout.
module dimer_low_complexity_check (
    input  logic  clk,
    input  logic  rst_n,
    dlc_seq_if.sink      seq,
    dlc_result_if.source result
);
    import dlc_pkg::*;

    psym_t  prev_reg;
    len_t   length_reg;
    len_t   len_inc;
    psym_t  sym;
    logic   accept;

    logic   s1_valid_reg, s1_valid_next;
    logic   s1_pair_reg;
    logic   s1_last_reg;
    addr_t  s1_addr_reg;
    len_t   s1_len_reg;
    logic   s1_go;

    logic   out_valid_reg, out_valid_next;
    logic   out_low_reg;
    len_t   out_len_reg;

    dlc_req_t req;
    dlc_upd_t upd;
    count_t   max_next;
    logic     busy;
    cmp_t     max3;
    cmp_t     thr;
    logic     low;

    assign sym       = seq.symbol[SYMBOL_BITS-1:0];
    assign seq.ready = !busy && !(s1_valid_reg && s1_last_reg);
    assign accept    = seq.valid && seq.ready;
    assign len_inc   = (length_reg == LEN_MAX) ? length_reg : length_reg + len_t'(1);

    assign req = '{rd: accept && (length_reg != '0), addr: {prev_reg, sym}};

    assign s1_go = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign upd   = '{wr: s1_go && s1_pair_reg, seq_end: s1_go && s1_last_reg,
                     addr: s1_addr_reg};

    dlc_pair_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .upd      (upd),
        .max_next (max_next),
        .busy     (busy)
    );

    // max > floor((len-2)/3) is the same as 3*max > len-2
    always_comb
    begin
        max3 = cmp_t'(max_next) + (cmp_t'(max_next) << 1);
        thr  = cmp_t'(s1_len_reg - len_t'(PAIR_LEN));
        low  = (s1_len_reg >= len_t'(PAIR_LEN)) && (max3 > thr);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_go)
            s1_valid_next = 1'b0;
        if (accept)
            s1_valid_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        if (upd.seq_end)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            length_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                prev_reg   <= seq.last ? '0 : sym;
                length_reg <= seq.last ? '0 : len_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pair_reg <= length_reg != '0;
            s1_last_reg <= seq.last;
            s1_addr_reg <= {prev_reg, sym};
            s1_len_reg  <= len_inc;
        end
        if (upd.seq_end)
        begin
            out_low_reg <= low;
            out_len_reg <= s1_len_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.low_complexity = out_low_reg;
    assign result.seq_length     = out_len_reg;

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid_reg && !result.ready |=> s1_valid_reg)
        else $error("last symbol dropped while result stalled");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_len_reg != '0)
        else $error("result with zero length");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.seq_length)
            && $stable(result.low_complexity))
        else $error("result changed while waiting");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dlc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned IDLE_PCT     = 8;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 120;
    localparam int unsigned NO_GAP_ITEMS = 80;
    localparam int unsigned SHORT_SEQS   = 250;
    localparam int unsigned THIRD        = 3;

    typedef struct {
        logic low;
        len_t len;
    } verdict_t;

    // Tracks pair counts per sequence and queues the verdict due on each last symbol
    class dimer_scoreboard;
        count_t   pair_tab[addr_t];
        psym_t    prev_sym;
        len_t     sym_count;
        count_t   peak;
        verdict_t verdicts[$];
        int       errors;

        function new();
            prev_sym  = '0;
            sym_count = '0;
            peak      = '0;
            errors    = 0;
        endfunction

        function void note_symbol(byte_t s, logic l);
            psym_t       cur;
            addr_t       idx;
            count_t      c;
            int unsigned thr;
            verdict_t    v;
            cur = psym_t'(s);
            if (sym_count != '0)
            begin
                idx = {prev_sym, cur};
                c = pair_tab.exists(idx) ? pair_tab[idx] : count_t'(0);
                if (c != COUNT_MAX)
                    c++;
                pair_tab[idx] = c;
                if (c > peak)
                    peak = c;
            end
            prev_sym = cur;
            if (sym_count != LEN_MAX)
                sym_count++;
            if (l)
            begin
                v.len = sym_count;
                v.low = 1'b0;
                if (sym_count >= PAIR_LEN)
                begin
                    thr   = (32'(sym_count) - PAIR_LEN) / THIRD;
                    v.low = (32'(peak) > thr);
                end
                verdicts.insert(verdicts.size(), v);
                pair_tab.delete();
                prev_sym  = '0;
                sym_count = '0;
                peak      = '0;
            end
        endfunction

        function void check_verdict(logic low, len_t len);
            verdict_t v;
            if (verdicts.size() == 0)
            begin
                $error("result with nothing expected: low_complexity %0d seq_length %0d",
                       low, len);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            if (low !== v.low)
            begin
                $error("low_complexity: expected %0d, actual %0d", v.low, low);
                errors++;
            end
            if (len !== v.len)
            begin
                $error("seq_length: expected %0d, actual %0d", v.len, len);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    bit   hold_req;
    int unsigned cycles = 0;
    int unsigned items_sent;

    dimer_scoreboard book;

    dlc_seq_if    seq_ch ();
    dlc_result_if res_ch ();

    dimer_low_complexity_check i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .seq    (seq_ch),
        .result (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                book.check_verdict(res_ch.low_complexity, res_ch.seq_length);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_symbol(input byte_t s, input logic l);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            seq_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seq_ch.valid  <= 1'b1;
        seq_ch.symbol <= s;
        seq_ch.last   <= l;
        @(posedge clk);
        while (!seq_ch.ready)
            @(posedge clk);
        book.note_symbol(s, l);
        items_sent++;
    endtask

    task automatic send_sequence(input byte_t body[$]);
        foreach (body[k])
            send_symbol(body[k], k == body.size() - 1);
    endtask

    // Content styles: free bytes, small alphabet, tandem repeat, repeat with noise
    task automatic send_random_sequence(input int unsigned len);
        byte_t       body[$];
        byte_t       alpha[4];
        int unsigned style;
        int unsigned period;
        style  = $urandom_range(3);
        period = $urandom_range(1, 4);
        foreach (alpha[k])
            alpha[k] = byte_t'($urandom);
        for (int unsigned n = 0; n < len; n++)
        begin
            case (style)
                0:       body.insert(body.size(), byte_t'($urandom));
                1:       body.insert(body.size(), alpha[$urandom_range(1, 3)]);
                2:       body.insert(body.size(), alpha[n % period]);
                default: body.insert(body.size(),
                                     ($urandom_range(9) == 0) ? byte_t'($urandom)
                                                              : alpha[n % period]);
            endcase
        end
        send_sequence(body);
    endtask

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return $urandom_range(1, 2);
        else if (roll < 85)
            return $urandom_range(3, 8);
        return $urandom_range(9, 30);
    endfunction

    initial
    begin : stimulus
        byte_t       body[$];
        int unsigned target;
        book       = new();
        no_gaps    = 1'b0;
        hold_req   = 1'b0;
        items_sent = 0;
        seq_ch.valid  <= 1'b0;
        seq_ch.symbol <= '0;
        seq_ch.last   <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // single-symbol sequences: no pair at all; then a two-symbol one with one pair
        body = {8'h00};
        send_sequence(body);
        body = {8'hFF};
        send_sequence(body);
        body = {8'hFF, 8'h00};
        send_sequence(body);
        // length 5, threshold 1: a repeated pair tips it, distinct pairs do not
        body = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        send_sequence(body);
        body = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10};
        send_sequence(body);
        // length 8, threshold 2: max count of 2 stays below, 3 goes over
        body = {8'h01, 8'h02, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
        send_sequence(body);
        body = {8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02, 8'h03, 8'h04};
        send_sequence(body);
        // same pair back to back exercises the write-back forwarding
        body = {8'h80, 8'h80, 8'h80, 8'h80};
        send_sequence(body);

        // many short sequences: crosses the periodic table clear and, with the
        // result side held off, fills the block so the input stalls
        hold_req = 1'b1;
        for (int unsigned n = 0; n < SHORT_SEQS; n++)
            send_random_sequence($urandom_range(1, 3));

        target = items_sent + RANDOM_ITEMS;
        no_gaps = 1'b1;
        while (items_sent < target)
        begin
            if (no_gaps && items_sent + RANDOM_ITEMS - target > NO_GAP_ITEMS)
                no_gaps = 1'b0;
            send_random_sequence(pick_length());
        end
        seq_ch.valid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
